// ===== sv/sdfa_pkg.sv =====
`default_nettype none
package sdfa_pkg;

	localparam int PARTICLES = 1024;
	localparam int IDX_W     = 10;
	localparam int PAW       = $clog2(3 * PARTICLES);
	localparam int MAW       = $clog2(PARTICLES);
	localparam int IN_W      = 280;
	localparam int OUT_W     = 96;
	localparam int CFG_W     = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] REG_STIFF = 2'd0;
	localparam logic [1:0] REG_DAMP  = 2'd1;
	localparam logic [1:0] REG_PULL  = 2'd2;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sh0_7FFF_FFFF)
			return 32'h7FFF_FFFF;
		if (v < -65'sh0_8000_0000)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/spring_damper_force_accumulator_core.sv =====
// Channel  Dir  Handshake           Payload
// s        in   s_tvalid/s_tready   s_tdata (particle/spring request), s_tuser (op)
// m        out  m_tvalid/m_tready   m_tdata (force x,y,z), m_tuser (zero_length)
// cfg      in   cfg_wen             cfg_index, cfg_wdata
// A spring runs four bit-serial divisions by the length, a square root and twelve
// products on one 32x32 multiplier, each summed from its 32-bit partial products.
// s_tready is high only between requests; a read waits for the output register to free.
// Reset clears control and the damp and pull registers and sets stiff to 0x10000;
// the particle stores hold garbage until loaded.
`default_nettype none
module spring_damper_force_accumulator_core import sdfa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// index_a, index_b, rest_length, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass
	input  wire logic [IN_W-1:0]   s_tdata,
	// op
	input  wire logic [1:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// force_x, force_y, force_z
	output logic [OUT_W-1:0]       m_tdata,
	// zero_length
	output logic                   m_tuser,
	input  wire logic              cfg_wen,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_RDF, ST_OUT, ST_SRD, ST_SETUP, ST_MUL, ST_POST,
		ST_DIV, ST_FIN, ST_SQRT, ST_LCHK, ST_FRA, ST_FWA, ST_FRB, ST_FWB
	} state_t;

	typedef enum logic [2:0] {K_SQ, K_K, K_S, K_DOT, K_DAMP, K_F} step_t;

	state_t state_q;
	step_t  step_q;
	logic [6:0] cnt_q;
	logic [1:0] idx_q;

	logic [31:0] stiff_q, damp_q;
	logic        pulln_q, flag_q, flag_rd_q, rdok_q;

	logic [IDX_W-1:0] a_q, b_q;
	logic [30:0]      rest_q, mass_in_q;
	logic [31:0]      pin_q [3];
	logic [31:0]      vin_q [3];
	logic [31:0]      fo_q  [3];

	logic signed [32:0] d_q [3];
	logic signed [32:0] dv_q [3];
	logic [31:0] pa_q, va_q;

	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [127:0] prod_q;
	logic [67:0]  sum_q;
	logic [35:0]  rem_q;
	logic [33:0]  len_q;
	logic [46:0]  k_q;
	logic signed [63:0] s_q, dot_q, f_q;

	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tuser_q, m_tvalid_q;

	logic [31:0] pos_mem [3*PARTICLES];
	logic [31:0] vel_mem [3*PARTICLES];
	logic [31:0] frc_mem [3*PARTICLES];
	logic [31:0] mass_mem [PARTICLES];
	logic [31:0] pos_rd_q, vel_rd_q, frc_rd_q, mass_rd_q;

	logic           pos_we, frc_we;
	logic [PAW-1:0] pos_waddr, pos_raddr, frc_waddr, frc_raddr;
	logic [31:0]    frc_wdata;
	logic [PAW-1:0] a3, b3;
	logic [MAW-1:0] ma_addr;

	logic [35:0] pull36;
	logic [31:0] pull32;
	logic        accept, a_ok, b_ok, out_free;

	logic [31:0]  mul_x, mul_y;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [34:0]  div_t;
	logic [37:0]  sq_rem;
	logic [35:0]  sq_trial;
	logic [63:0]  q16, qdiv;
	logic signed [63:0] res16, resdiv;
	logic signed [34:0] lr;
	logic signed [63:0] d64, dv64;
	logic [2:0]   pidx;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign a3 = PAW'({a_q, 1'b0}) + PAW'(a_q);
	assign b3 = PAW'({b_q, 1'b0}) + PAW'(b_q);
	assign ma_addr = MAW'(a_q);
	assign pidx = cnt_q[2:0] - 3'd1;

	assign pull36 = 36'({mass_in_q, 4'b0}) + 36'({mass_in_q, 2'b0});
	always_comb begin
		if (!pulln_q)
			pull32 = (pull36 > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : pull36[31:0];
		else
			pull32 = (pull36 > 36'h0_8000_0000) ? 32'h8000_0000 : 32'(-pull36[31:0]);
	end

	always_comb begin
		pos_we    = (state_q == ST_LOAD);
		pos_waddr = a3 + PAW'(cnt_q[1:0]);
		pos_raddr = (cnt_q[0] ? b3 : a3) + PAW'(cnt_q[2:1]);
		frc_we    = 1'b0;
		frc_waddr = a3 + PAW'(cnt_q[1:0]);
		frc_wdata = (cnt_q[1:0] == 2'd0) ? pull32 : 32'd0;
		frc_raddr = a3 + PAW'(idx_q);
		unique case (state_q)
			ST_LOAD: begin
				frc_we = 1'b1;
			end
			ST_RDF: begin
				frc_raddr = a3 + PAW'(cnt_q[1:0]);
			end
			ST_FRB: begin
				frc_raddr = b3 + PAW'(idx_q);
			end
			ST_FWA: begin
				frc_we    = 1'b1;
				frc_waddr = a3 + PAW'(idx_q);
				frc_wdata = sat32(65'(signed'(frc_rd_q)) + 65'(f_q));
			end
			ST_FWB: begin
				frc_we    = 1'b1;
				frc_waddr = b3 + PAW'(idx_q);
				frc_wdata = sat32(65'(signed'(frc_rd_q)) - 65'(f_q));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= pin_q[cnt_q[1:0]];
			vel_mem[pos_waddr] <= vin_q[cnt_q[1:0]];
		end
		pos_rd_q <= pos_mem[pos_raddr];
		vel_rd_q <= vel_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (frc_we)
			frc_mem[frc_waddr] <= frc_wdata;
		frc_rd_q <= frc_mem[frc_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && cnt_q[1:0] == 2'd0)
			mass_mem[ma_addr] <= {1'b0, mass_in_q};
		mass_rd_q <= mass_mem[ma_addr];
	end

	assign a_ok = 32'(s_tdata[IDX_W-1:0]) < PARTICLES;
	assign b_ok = 32'(s_tdata[2*IDX_W-1:IDX_W]) < PARTICLES;

	assign mul_x = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign mul_y = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp    = 64'(mul_x) * 64'(mul_y);
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    pp_sh = 128'(pp);
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	assign div_t    = {rem_q[33:0], prod_q[63]};
	assign sq_rem   = {rem_q, sum_q[67:66]};
	assign sq_trial = {len_q, 2'b01};

	assign q16    = (prod_q[127:79] != '0) ? 64'(S64_MAX) : {1'b0, prod_q[78:16]};
	assign res16  = neg_q ? -signed'(q16) : signed'(q16);
	assign qdiv   = prod_q[63] ? 64'(S64_MAX) : prod_q[63:0];
	assign resdiv = neg_q ? -signed'(qdiv) : signed'(qdiv);
	assign lr     = signed'({1'b0, len_q}) - signed'({4'b0, rest_q});
	assign d64    = 64'(d_q[idx_q]);
	assign dv64   = 64'(dv_q[idx_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= K_SQ;
			cnt_q      <= '0;
			idx_q      <= '0;
			stiff_q    <= 32'h0001_0000;
			damp_q     <= '0;
			pulln_q    <= 1'b0;
			flag_q     <= 1'b0;
			flag_rd_q  <= 1'b0;
			rdok_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_STIFF: stiff_q <= cfg_wdata;
					REG_DAMP:  damp_q  <= cfg_wdata;
					REG_PULL:  pulln_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						a_q       <= s_tdata[9:0];
						b_q       <= s_tdata[19:10];
						rest_q    <= s_tdata[50:20];
						pin_q[0]  <= s_tdata[82:51];
						pin_q[1]  <= s_tdata[114:83];
						pin_q[2]  <= s_tdata[146:115];
						vin_q[0]  <= s_tdata[178:147];
						vin_q[1]  <= s_tdata[210:179];
						vin_q[2]  <= s_tdata[242:211];
						mass_in_q <= s_tdata[273:243];
						cnt_q     <= '0;
						rdok_q    <= a_ok;
						case (s_tuser)
							OP_LOAD: state_q <= a_ok ? ST_LOAD : ST_FIN;
							OP_RUN:  state_q <= (a_ok && b_ok) ? ST_SRD : ST_FIN;
							OP_READ: begin
								state_q   <= ST_RDF;
								flag_rd_q <= flag_q;
								flag_q    <= 1'b0;
							end
							default: state_q <= ST_FIN;
						endcase
						step_q <= K_K;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[1:0] == 2'd2)
						state_q <= ST_IDLE;
				end
				ST_RDF: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q != '0)
						fo_q[cnt_q[1:0] - 2'd1] <= frc_rd_q;
					if (cnt_q[1:0] == 2'd3)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tdata_q  <= rdok_q ? {fo_q[2], fo_q[1], fo_q[0]} : '0;
						m_tuser_q  <= flag_rd_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_SRD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q != '0) begin
						if (!pidx[0]) begin
							pa_q <= pos_rd_q;
							va_q <= vel_rd_q;
						end else begin
							d_q[pidx[2:1]]  <= 33'(signed'(pa_q)) - 33'(signed'(pos_rd_q));
							dv_q[pidx[2:1]] <= 33'(signed'(va_q)) - 33'(signed'(vel_rd_q));
						end
					end
					if (cnt_q[2:0] == 3'd6) begin
						step_q  <= K_SQ;
						idx_q   <= '0;
						sum_q   <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					prod_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_MUL;
					case (step_q)
						K_SQ: begin
							ma_q  <= mag64(d64);
							mb_q  <= mag64(d64);
							neg_q <= 1'b0;
						end
						K_K: begin
							ma_q  <= 64'(stiff_q);
							mb_q  <= 64'(mass_rd_q);
							neg_q <= 1'b0;
						end
						K_S: begin
							ma_q  <= 64'(k_q);
							mb_q  <= mag64(64'(lr));
							neg_q <= lr[34];
						end
						K_DOT: begin
							ma_q  <= mag64(dv64);
							mb_q  <= mag64(d64);
							neg_q <= dv64[63] ^ d64[63];
						end
						K_DAMP: begin
							ma_q  <= 64'(damp_q);
							mb_q  <= mag64(dot_q);
							neg_q <= dot_q[63];
						end
						default: begin
							ma_q  <= mag64(s_q);
							mb_q  <= mag64(d64);
							neg_q <= s_q[63] ^ d64[63];
						end
					endcase
				end
				ST_MUL: begin
					prod_q <= prod_q + pp_sh;
					cnt_q  <= cnt_q + 7'd1;
					if (cnt_q[1:0] == 2'd3)
						state_q <= ST_POST;
				end
				ST_POST: begin
					cnt_q   <= '0;
					state_q <= ST_SETUP;
					case (step_q)
						K_SQ: begin
							sum_q <= sum_q + prod_q[67:0];
							idx_q <= idx_q + 2'd1;
							if (idx_q == 2'd2) begin
								rem_q   <= '0;
								len_q   <= '0;
								state_q <= ST_SQRT;
							end
						end
						K_K: begin
							k_q    <= prod_q[62:16];
							step_q <= K_S;
						end
						K_S: begin
							s_q    <= res16;
							dot_q  <= '0;
							idx_q  <= '0;
							step_q <= K_DOT;
						end
						K_DOT: begin
							dot_q <= dot_q + res16;
							idx_q <= idx_q + 2'd1;
							if (idx_q == 2'd2)
								step_q <= K_DAMP;
						end
						default: begin
							if (prod_q[127:64] >= 64'(len_q)) begin
								prod_q[63:0] <= '1;
								state_q      <= ST_FIN;
							end else begin
								rem_q   <= 36'(prod_q[97:64]);
								state_q <= ST_DIV;
							end
						end
					endcase
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (div_t >= 35'(len_q)) begin
						rem_q        <= 36'(div_t - 35'(len_q));
						prod_q[63:0] <= {prod_q[62:0], 1'b1};
					end else begin
						rem_q        <= 36'(div_t);
						prod_q[63:0] <= {prod_q[62:0], 1'b0};
					end
					if (cnt_q == 7'd63)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					case (step_q)
						K_DAMP: begin
							s_q     <= sat_add64(s_q, resdiv);
							idx_q   <= '0;
							step_q  <= K_F;
							state_q <= ST_SETUP;
						end
						K_F: begin
							f_q     <= -resdiv;
							state_q <= ST_FRA;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 7'd1;
					sum_q <= {sum_q[65:0], 2'b00};
					if (sq_rem >= 38'(sq_trial)) begin
						rem_q <= 36'(sq_rem - 38'(sq_trial));
						len_q <= {len_q[32:0], 1'b1};
					end else begin
						rem_q <= sq_rem[35:0];
						len_q <= {len_q[32:0], 1'b0};
					end
					if (cnt_q == 7'd33)
						state_q <= ST_LCHK;
				end
				ST_LCHK: begin
					if (len_q == '0) begin
						flag_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						step_q  <= K_K;
						state_q <= ST_SETUP;
					end
				end
				ST_FRA: state_q <= ST_FWA;
				ST_FWA: state_q <= ST_FRB;
				ST_FRB: state_q <= ST_FWB;
				ST_FWB: begin
					idx_q <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd2) ? ST_IDLE : ST_SETUP;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/sdfa_checker.sv =====
`default_nettype none
module sdfa_checker import sdfa_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic             m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// busy after every request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready straight after a request");

	// results appear only out of a busy cycle
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a request in flight");

endmodule

bind spring_damper_force_accumulator_core sdfa_checker u_sdfa_checker (.*);
`default_nettype wire
